/* rtl/vdss_pkg.sv */
// Shared types, constants and the segment decoder of the voltage-difference scanner.
package vdss_pkg;

  localparam int unsigned SampleBits  = 12;
  localparam int unsigned DigitCount  = 4;
  localparam int unsigned ScanW       = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam int unsigned DwellW      = 8;
  localparam int unsigned ValueW      = 10;
  localparam int unsigned ValueDigits = 4;
  localparam int unsigned ProdW       = SampleBits + ValueW;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);

  localparam logic [SampleBits-1:0] SampleMax       = '1;
  localparam logic [DwellW-1:0]     DwellTicksReset = 8'd3;
  localparam logic [ValueW-1:0]     FullScaleReset  = 10'd330;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DWELL_TICKS = 8'd0,
    REG_FULL_SCALE  = 8'd1
  } reg_idx_e;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    op_e                   op;
    logic [SampleBits-1:0] diff;
  } cmd_t;

  typedef struct packed {
    logic [DwellW-1:0] dwell_ticks;
    logic [ValueW-1:0] full_scale;
  } cfg_t;

  // Common-cathode pattern, segments a..g in bits 0..6.
  function automatic logic [6:0] seg_of(input bcd_t digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

/* rtl/vdss_if.sv */
// Handshake channels of the scanner: input items, result items and register writes.
interface vdss_in_if;
  import vdss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [SampleBits-1:0] sample_a;
  logic [SampleBits-1:0] sample_b;
  modport source (output valid, operation, sample_a, sample_b, input ready);
  modport sink   (input valid, operation, sample_a, sample_b, output ready);
endinterface

interface vdss_out_if;
  import vdss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [6:0]            segments;
  logic [DigitCount-1:0] digit_enable;
  modport source (output valid, segments, digit_enable, input ready);
  modport sink   (input valid, segments, digit_enable, output ready);
endinterface

interface vdss_cfg_if;
  import vdss_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/voltage_difference_seven_segment_scanner.sv */
// Top level of the voltage-difference seven-segment scanner.
// Each accepted item gives one result: the segment pattern and one-hot enable of the
// digit lit after that item. A sample pair replaces the shown value with
// floor(|a - b| * full_scale / 4095), a tick advances the dwell count and, once it reaches
// the dwell limit, steps the scan from units to thousands and round again. One item is taken
// per cycle while results are taken as fast; a result passes through the two-entry queue,
// the scale multiplier, the constant divider, the decimal split and the result register.
// Register writes take effect at once and are meant for idle times.
module voltage_difference_seven_segment_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdss_in_if.sink     in_i,
  vdss_out_if.source  out_o,
  vdss_cfg_if.sink    cfg_i
);
  import vdss_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;
  cfg_t cfg;

  vdss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .cfg_o        (cfg)
  );

  vdss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  vdss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .cfg_i       (cfg),
    .out_o       (out_o)
  );

endmodule

/* rtl/vdss_front.sv */
// Front end: takes items, classifies them, forms the sample difference; holds the registers.
module vdss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdss_in_if.sink       in_i,
  vdss_cfg_if.sink      cfg_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output vdss_pkg::cmd_t push_cmd_o,
  output vdss_pkg::cfg_t cfg_o
);
  import vdss_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_cmd_o.op = op_e'(in_i.operation);
    if (in_i.sample_a >= in_i.sample_b) begin
      push_cmd_o.diff = in_i.sample_a - in_i.sample_b;
    end else begin
      push_cmd_o.diff = in_i.sample_b - in_i.sample_a;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DWELL_TICKS: cfg_d.dwell_ticks = cfg_i.data[DwellW-1:0];
        REG_FULL_SCALE:  cfg_d.full_scale  = cfg_i.data[ValueW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell_ticks <= DwellTicksReset;
      cfg_q.full_scale  <= FullScaleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/vdss_queue.sv */
// Short command queue between the front end and the back end.
module vdss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  vdss_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output vdss_pkg::cmd_t pop_cmd_o
);
  import vdss_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/vdss_back.sv */
// Back end: scale, divide, decimal split, display state and the result register.
module vdss_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  vdss_pkg::cmd_t pop_cmd_i,
  input  vdss_pkg::cfg_t cfg_i,
  vdss_out_if.source     out_o
);
  import vdss_pkg::*;

  // Stage enables, from the result register backwards.
  logic en1, en2, en3, en_o, load_o;

  // Stage 1: product of difference and full scale.
  logic             s1_v_q;
  op_e              s1_op_q;
  logic [ProdW-1:0] s1_prod_q;

  // Stage 2: quotient by the sample maximum.
  logic              s2_v_q;
  op_e               s2_op_q;
  logic [ValueW-1:0] s2_quot_q;

  // Stage 3: decimal digits.
  logic s3_v_q;
  op_e  s3_op_q;
  bcd_t s3_dig_q [DigitCount];
  bcd_t s3_dig_d [DigitCount];

  // Display state and result register.
  bcd_t                  held_q [DigitCount];
  bcd_t                  held_d [DigitCount];
  logic [ScanW-1:0]      pos_q, pos_d;
  logic [DwellW-1:0]     cnt_q, cnt_d;
  logic                  out_v_q;
  logic [6:0]            seg_q, seg_d;
  logic [DigitCount-1:0] en_q, en_d;

  assign en_o        = !out_v_q || out_o.ready;
  assign en3         = !s3_v_q || en_o;
  assign en2         = !s2_v_q || en3;
  assign en1         = !s1_v_q || en2;
  assign pop_ready_o = en1;
  assign load_o      = en_o && s3_v_q;

  // Divide by 2^SampleBits - 1: estimate by shifts, then one correction step.
  logic [ProdW:0]    est_sum, est_back, est_rem;
  logic [ValueW:0]   est_q;
  logic [ValueW-1:0] quot_d;

  always_comb begin
    est_sum  = {1'b0, s1_prod_q} + (ProdW + 1)'(s1_prod_q >> SampleBits);
    est_q    = est_sum[ProdW -: (ValueW + 1)];
    est_back = ((ProdW + 1)'(est_q) << SampleBits) - (ProdW + 1)'(est_q);
    est_rem  = {1'b0, s1_prod_q} - est_back;
    if (est_rem >= (ProdW + 1)'(SampleMax)) begin
      quot_d = ValueW'(est_q + 1'b1);
    end else begin
      quot_d = ValueW'(est_q);
    end
  end

  // Decimal split by reciprocal multiplies, exact for values below 1024.
  logic [17:0] mul10;
  logic [15:0] mul100;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic        q1000;
  bcd_t        val_dig [ValueDigits];

  always_comb begin
    mul10      = 18'(s2_quot_q) * 18'd205;
    mul100     = 16'(s2_quot_q) * 16'd41;
    q10        = mul10[17:11];
    q100       = mul100[15:12];
    q1000      = (s2_quot_q >= ValueW'(1000));
    val_dig[0] = 4'(s2_quot_q - ValueW'(q10) * ValueW'(10));
    val_dig[1] = 4'(q10 - 7'(q100) * 7'd10);
    val_dig[2] = 4'(q100 - 4'(q1000) * 4'd10);
    val_dig[3] = 4'(q1000);
    for (int i = 0; i < DigitCount; i++) begin
      if (i < ValueDigits) begin
        s3_dig_d[i] = val_dig[i];
      end else begin
        s3_dig_d[i] = '0;
      end
    end
  end

  // Display state update and the pattern of the digit now lit.
  logic [DwellW-1:0] limit;
  logic [DwellW:0]   next_cnt;

  always_comb begin
    held_d   = held_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    limit    = (cfg_i.dwell_ticks == '0) ? DwellW'(1) : cfg_i.dwell_ticks;
    next_cnt = {1'b0, cnt_q} + 1'b1;
    if (s3_op_q == OP_SAMPLE) begin
      held_d = s3_dig_q;
    end else if (next_cnt >= {1'b0, limit}) begin
      cnt_d = '0;
      pos_d = (pos_q == ScanW'(DigitCount - 1)) ? '0 : pos_q + 1'b1;
    end else begin
      cnt_d = next_cnt[DwellW-1:0];
    end
    seg_d = seg_of(held_d[pos_d]);
    en_d  = DigitCount'(1) << pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < DigitCount; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      if (en1) begin
        s1_v_q <= pop_valid_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en_o) begin
        out_v_q <= s3_v_q;
      end
      if (load_o) begin
        held_q <= held_d;
        pos_q  <= pos_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && pop_valid_i) begin
      s1_op_q   <= pop_cmd_i.op;
      s1_prod_q <= ProdW'(pop_cmd_i.diff) * ProdW'(cfg_i.full_scale);
    end
    if (en2 && s1_v_q) begin
      s2_op_q   <= s1_op_q;
      s2_quot_q <= quot_d;
    end
    if (en3 && s2_v_q) begin
      s3_op_q  <= s2_op_q;
      s3_dig_q <= s3_dig_d;
    end
    if (load_o) begin
      seg_q <= seg_d;
      en_q  <= en_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_enable = en_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= ScanW'(DigitCount - 1))
    else $error("scan position beyond the last digit");

  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $onehot(out_o.digit_enable))
    else $error("digit enable not one-hot on a valid result");

  a_sample_keeps_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_o && s3_op_q == OP_SAMPLE) |=> ($stable(pos_q) && $stable(cnt_q)))
    else $error("sample item moved the scan");

endmodule

/* test/tb_voltage_difference_seven_segment_scanner.sv */
// Self-checking testbench for the voltage-difference seven-segment scanner.
module tb_voltage_difference_seven_segment_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import vdss_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 112;
  localparam int unsigned SettleCycles = 8;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] RegUnmapped = 8'hA5;

  localparam logic [6:0] SegPattern [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [6:0]            segments;
    logic [DigitCount-1:0] digit_enable;
  } disp_t;

  typedef struct packed {
    bit    typed;
    disp_t want;
  } pinned_t;

  typedef struct {
    bit                    is_cfg;
    logic [CfgIdxW-1:0]    index;
    logic [CfgDataW-1:0]   data;
    op_e                   op;
    logic [SampleBits-1:0] a;
    logic [SampleBits-1:0] b;
    bit                    typed;
    disp_t                 want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vdss_in_if  in_ch ();
  vdss_out_if out_ch ();
  vdss_cfg_if cfg_ch ();

  voltage_difference_seven_segment_scanner uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Display state as the block should hold it
  logic [DwellW-1:0] dwell_ticks = DwellTicksReset;
  logic [ValueW-1:0] full_scale  = FullScaleReset;
  logic [ValueW-1:0] shown_value = '0;
  logic [ScanW-1:0]  scan_pos    = '0;
  logic [DwellW-1:0] dwell_count = '0;

  disp_t   display_q [$];
  pinned_t pinned_q [$];

  int errors      = 0;
  int items_sent  = 0;
  int results_ok  = 0;
  int reg_writes  = 0;
  int scan_steps  = 0;
  int sample_cnt  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_count = 0;

  function automatic disp_t advance_display(input op_e op, input logic [SampleBits-1:0] a,
                                            input logic [SampleBits-1:0] b);
    logic [SampleBits-1:0] gap;
    logic [ProdW-1:0]      scaled;
    logic [DwellW:0]       next_cnt;
    logic [DwellW:0]       dwell_limit;
    logic [ValueW-1:0]     digits;
    disp_t                 res;
    if (op == OP_SAMPLE) begin
      gap         = (a >= b) ? a - b : b - a;
      scaled      = ProdW'(gap) * ProdW'(full_scale);
      shown_value = ValueW'(scaled / ProdW'(SampleMax));
      sample_cnt++;
    end else begin
      // a zero dwell behaves as one tick per digit
      dwell_limit = (dwell_ticks == '0) ? 9'd1 : {1'b0, dwell_ticks};
      next_cnt    = {1'b0, dwell_count} + 9'd1;
      if (next_cnt >= dwell_limit) begin
        dwell_count = '0;
        scan_pos    = (scan_pos == ScanW'(DigitCount - 1)) ? '0 : scan_pos + 1'b1;
        scan_steps++;
      end else begin
        dwell_count = next_cnt[DwellW-1:0];
      end
    end
    digits = shown_value;
    for (int i = 0; i < int'(scan_pos); i++) digits = digits / 10;
    res.segments     = SegPattern[digits % 10];
    res.digit_enable = DigitCount'(1) << scan_pos;
    return res;
  endfunction

  function automatic row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
    row_t r;
    r        = '{default: '0, op: OP_SAMPLE};
    r.is_cfg = 1'b1;
    r.index  = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t item_row(input op_e op, input logic [SampleBits-1:0] a,
                                    input logic [SampleBits-1:0] b);
    row_t r;
    r    = '{default: '0, op: OP_SAMPLE};
    r.op = op;
    r.a  = a;
    r.b  = b;
    return r;
  endfunction

  function automatic row_t shown_row(input op_e op, input logic [SampleBits-1:0] a,
                                     input logic [SampleBits-1:0] b, input logic [6:0] seg,
                                     input logic [DigitCount-1:0] en);
    row_t r;
    r       = item_row(op, a, b);
    r.typed = 1'b1;
    r.want  = '{segments: seg, digit_enable: en};
    return r;
  endfunction

  // Checker: predict on every accepted item, compare every accepted result
  always @(posedge clk_i) begin
    disp_t   want;
    disp_t   got;
    pinned_t pin;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DWELL_TICKS: dwell_ticks = cfg_ch.data[DwellW-1:0];
          REG_FULL_SCALE:  full_scale  = cfg_ch.data[ValueW-1:0];
          default: ;
        endcase
        reg_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = advance_display(op_e'(in_ch.operation), in_ch.sample_a, in_ch.sample_b);
        pin  = pinned_q.pop_front();
        display_q.push_back(pin.typed ? pin.want : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{segments: out_ch.segments, digit_enable: out_ch.digit_enable};
        if (display_q.size() == 0) begin
          $error("result with nothing expected: segments %h digit_enable %b",
                 got.segments, got.digit_enable);
          errors++;
        end else begin
          want = display_q.pop_front();
          if (got.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, got.segments);
            errors++;
          end
          if (got.digit_enable !== want.digit_enable) begin
            $error("digit_enable: expected %b, got %b", want.digit_enable, got.digit_enable);
            errors++;
          end
          results_ok++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= StallLimit) begin
      $display("timeout: no handshake for %0d cycles", StallLimit);
      $display("tb_voltage_difference_seven_segment_scanner: done, errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Drop the item valid and hold until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (display_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(input op_e op, input logic [SampleBits-1:0] a,
                           input logic [SampleBits-1:0] b, input bit typed, input disp_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pinned_q.push_back('{typed: typed, want: want});
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.sample_a  <= a;
    in_ch.sample_b  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  initial begin
    row_t                  directed [$];
    logic [SampleBits-1:0] a;
    logic [SampleBits-1:0] b;
    logic [DwellW-1:0]     dwell;
    logic [ValueW-1:0]     scale;
    op_e                   op;

    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_SAMPLE;
    in_ch.sample_a   = '0;
    in_ch.sample_b   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_DWELL_TICKS;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      shown_row(OP_SAMPLE, 12'd0, 12'd0, SegPattern[0], 4'b0001),
      shown_row(OP_SAMPLE, SampleMax, 12'd0, SegPattern[0], 4'b0001),
      item_row(OP_TICK, 12'd0, 12'd0),
      item_row(OP_TICK, 12'd0, 12'd0),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[3], 4'b0010),
      shown_row(OP_SAMPLE, 12'd0, SampleMax, SegPattern[3], 4'b0010),
      item_row(OP_TICK, 12'd0, 12'd0),
      item_row(OP_TICK, 12'd0, 12'd0),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[3], 4'b0100),
      item_row(OP_TICK, 12'd0, 12'd0),
      item_row(OP_TICK, 12'd0, 12'd0),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[0], 4'b1000),
      // zero dwell: every tick steps the scan
      reg_row(REG_DWELL_TICKS, 16'hFF00),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[0], 4'b0001),
      reg_row(REG_FULL_SCALE, 16'hFFE7),
      shown_row(OP_SAMPLE, SampleMax, 12'd0, SegPattern[9], 4'b0001),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[9], 4'b0010),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[9], 4'b0100),
      shown_row(OP_TICK, 12'd0, 12'd0, SegPattern[0], 4'b1000),
      reg_row(REG_FULL_SCALE, 16'h0000),
      shown_row(OP_SAMPLE, SampleMax, 12'd0, SegPattern[0], 4'b1000),
      reg_row(RegUnmapped, 16'h0001),
      reg_row(REG_FULL_SCALE, 16'h0001),
      item_row(OP_SAMPLE, 12'd0, SampleMax),
      // raise the dwell, build up a count, then lower it below the count
      reg_row(REG_DWELL_TICKS, 16'h01FF),
      item_row(OP_TICK, 12'd0, 12'd0),
      item_row(OP_TICK, 12'd0, 12'd0),
      item_row(OP_TICK, SampleMax, 12'hAAA),
      reg_row(REG_DWELL_TICKS, 16'h0002),
      shown_row(OP_TICK, 12'h555, SampleMax, SegPattern[1], 4'b0001),
      reg_row(REG_FULL_SCALE, 16'd330),
      item_row(OP_SAMPLE, 12'd2049, 12'd1),
      item_row(OP_SAMPLE, 12'd1, 12'd2730),
      item_row(OP_SAMPLE, 12'd2048, 12'd2047)
    };
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].index, directed[i].data);
      end else begin
        send_item(directed[i].op, directed[i].a, directed[i].b, directed[i].typed,
                  directed[i].want);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       begin dwell = 8'd1;   scale = 10'd999; end
        1:       begin dwell = 8'd255; scale = 10'd1; end
        2:       begin dwell = 8'd0;   scale = 10'($urandom); end
        default: begin
          dwell = 8'($urandom_range(1, 6));
          scale = 10'($urandom_range(1, 999));
        end
      endcase
      write_reg(REG_DWELL_TICKS, {8'($urandom), dwell});
      write_reg(REG_FULL_SCALE, {6'($urandom), scale});
      write_reg(CfgIdxW'($urandom_range(2, 255)), 16'($urandom));
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0; end
        1:       begin idle_pct = 77; stall_pct = 0; end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      repeat (PhaseItems) begin
        op = op_e'($urandom_range(0, 1));
        a  = 12'($urandom);
        case ($urandom_range(0, 3))
          0:       b = a ^ 12'($urandom_range(0, 15));
          1: begin
            a = $urandom_range(0, 1) ? SampleMax : '0;
            b = $urandom_range(0, 1) ? SampleMax : 12'($urandom);
          end
          default: b = 12'($urandom);
        endcase
        send_item(op, a, b, 1'b0, '0);
      end
      drain_results();
      idle_pct  = 0;
      stall_pct = 0;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d items (%0d sample pairs) over %0d register writes and %0d phases",
             items_sent, sample_cnt, reg_writes, PhaseCount);
    $display("checked %0d results, scan stepped %0d times, %0d mismatches",
             results_ok, scan_steps, errors);
    if (errors == 0 && display_q.size() == 0) begin
      $display("tb_voltage_difference_seven_segment_scanner: done, clean");
    end else begin
      $display("tb_voltage_difference_seven_segment_scanner: done, errors");
    end
    $finish;
  end

endmodule

/* voltage_difference_seven_segment_scanner.f */
rtl/vdss_pkg.sv
rtl/vdss_if.sv
rtl/vdss_front.sv
rtl/vdss_queue.sv
rtl/vdss_back.sv
rtl/voltage_difference_seven_segment_scanner.sv
test/tb_voltage_difference_seven_segment_scanner.sv
